// ===== sv/jbt_pkg.sv =====
// ----------------------------------------------------------------------------
// jbt_pkg: shared types, codes and byte classes of the JSON byte tokeniser
// Lexer modes, token kinds, the result item and the decode bundle.
// ----------------------------------------------------------------------------
package jbt_pkg;

  // Lexer mode; codes above MODE_ESC never arise and behave as idle
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_NAME = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_STR  = 3'd3,
    MODE_ESC  = 3'd4
  } mode_t;

  // Token kinds as carried on the result channel
  localparam logic [1:0] KIND_PUNCT = 2'd0;
  localparam logic [1:0] KIND_NAME  = 2'd1;
  localparam logic [1:0] KIND_NUM   = 2'd2;
  localparam logic [1:0] KIND_STR   = 2'd3;

  // Characters of interest
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_UC_E   = 8'h45;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One result item
  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] byte_value;
    logic       has_byte;
    logic       first_of_token;
    logic       last_of_token;
    logic       string_error;
  } res_t;

  // Up to two results for one input byte
  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } dec_t;

  // Outcome of opening a token from idle
  typedef struct packed {
    logic  vld;
    res_t  res;
    mode_t mode;
  } start_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic in_name(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || (c == CH_USCORE);
  endfunction

  function automatic logic in_num(input logic [7:0] c);
    return is_digit(c) || (c == CH_DOT) || (c == CH_LC_E) || (c == CH_UC_E) ||
           (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_COLON) || (c == CH_COMMA) || (c == CH_LBRACE) ||
           (c == CH_RBRACE) || (c == CH_LBRACK) || (c == CH_RBRACK);
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] u;
    case (c)
      CH_LC_N: u = CH_LF;
      CH_LC_T: u = CH_TAB;
      CH_LC_R: u = CH_CR;
      default: u = c;
    endcase
    return u;
  endfunction

  // Build a result; the byte reads as zero when none is carried
  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] b,
                                  input logic has, input logic first,
                                  input logic last, input logic err);
    res_t r;
    r.token_kind     = kind;
    r.byte_value     = has ? b : 8'h00;
    r.has_byte       = has;
    r.first_of_token = first;
    r.last_of_token  = last;
    r.string_error   = err;
    return r;
  endfunction

  // Open a token on byte c while no token is open
  function automatic start_t start_tok(input logic [7:0] c);
    start_t s;
    s.vld  = 1'b1;
    s.mode = MODE_IDLE;
    s.res  = mk_res(KIND_PUNCT, c, 1'b1, 1'b1, 1'b1, 1'b0);
    if (is_punct(c)) begin
      s.mode = MODE_IDLE;
    end else if (c == CH_QUOTE) begin
      s.res  = mk_res(KIND_STR, c, 1'b0, 1'b1, 1'b0, 1'b0);
      s.mode = MODE_STR;
    end else if (is_digit(c)) begin
      s.res  = mk_res(KIND_NUM, c, 1'b1, 1'b1, 1'b0, 1'b0);
      s.mode = MODE_NUM;
    end else if (is_letter(c) || (c == CH_USCORE)) begin
      s.res  = mk_res(KIND_NAME, c, 1'b1, 1'b1, 1'b0, 1'b0);
      s.mode = MODE_NAME;
    end else begin
      s.vld = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== sv/jbt_if.sv =====
// ----------------------------------------------------------------------------
// jbt_if: stream channels of the JSON byte tokeniser
// Input byte channel and result item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface jbt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] byte_value;
  logic       has_byte;
  logic       first_of_token;
  logic       last_of_token;
  logic       string_error;

  modport source (output valid, output token_kind, output byte_value, output has_byte,
                  output first_of_token, output last_of_token, output string_error,
                  input ready);
  modport sink   (input valid, input token_kind, input byte_value, input has_byte,
                  input first_of_token, input last_of_token, input string_error,
                  output ready);
endinterface

// ===== sv/jbt_decode.sv =====
// ----------------------------------------------------------------------------
// jbt_decode: lexer mode register and per-byte result decode
// Turns one staged byte plus the current mode into up to two results.
// ----------------------------------------------------------------------------
module jbt_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  logic                end_of_input,
  output jbt_pkg::dec_t       dec
);

  jbt_pkg::mode_t  mode_r;
  jbt_pkg::mode_t  mode_nxt;
  jbt_pkg::start_t st;
  jbt_pkg::res_t   close_name;
  jbt_pkg::res_t   close_num;

  // Opening outcome and token closers, shared by several arms
  always_comb begin
    st         = jbt_pkg::start_tok(data_byte);
    close_name = jbt_pkg::mk_res(jbt_pkg::KIND_NAME, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    close_num  = jbt_pkg::mk_res(jbt_pkg::KIND_NUM, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
  end

  // Next mode
  always_comb begin
    mode_nxt = mode_r;
    if (end_of_input) begin
      mode_nxt = jbt_pkg::MODE_IDLE;
    end else begin
      unique case (mode_r)
        jbt_pkg::MODE_NAME: begin
          if (!jbt_pkg::in_name(data_byte)) begin
            mode_nxt = st.mode;
          end
        end
        jbt_pkg::MODE_NUM: begin
          if (!jbt_pkg::in_num(data_byte)) begin
            mode_nxt = st.mode;
          end
        end
        jbt_pkg::MODE_STR: begin
          if (data_byte == jbt_pkg::CH_QUOTE) begin
            mode_nxt = jbt_pkg::MODE_IDLE;
          end else if (data_byte == jbt_pkg::CH_BSLASH) begin
            mode_nxt = jbt_pkg::MODE_ESC;
          end
        end
        jbt_pkg::MODE_ESC: begin
          mode_nxt = jbt_pkg::MODE_STR;
        end
        default: begin
          // idle, and the unused codes
          mode_nxt = st.mode;
        end
      endcase
    end
  end

  // Result decode
  always_comb begin
    dec = '0;
    if (end_of_input) begin
      unique case (mode_r)
        jbt_pkg::MODE_NAME: begin
          dec.num  = 2'd1;
          dec.res0 = close_name;
        end
        jbt_pkg::MODE_NUM: begin
          dec.num  = 2'd1;
          dec.res0 = close_num;
        end
        jbt_pkg::MODE_STR: begin
          dec.num  = 2'd1;
          dec.res0 = jbt_pkg::mk_res(jbt_pkg::KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        end
        jbt_pkg::MODE_ESC: begin
          dec.num  = 2'd1;
          dec.res0 = jbt_pkg::mk_res(jbt_pkg::KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        end
        default: dec.num = 2'd0;
      endcase
    end else begin
      unique case (mode_r)
        jbt_pkg::MODE_NAME: begin
          if (jbt_pkg::in_name(data_byte)) begin
            dec.num  = 2'd1;
            dec.res0 = jbt_pkg::mk_res(jbt_pkg::KIND_NAME, data_byte, 1'b1, 1'b0, 1'b0,
                                       1'b0);
          end else begin
            dec.num  = {st.vld, ~st.vld};
            dec.res0 = close_name;
            dec.res1 = st.res;
          end
        end
        jbt_pkg::MODE_NUM: begin
          if (jbt_pkg::in_num(data_byte)) begin
            dec.num  = 2'd1;
            dec.res0 = jbt_pkg::mk_res(jbt_pkg::KIND_NUM, data_byte, 1'b1, 1'b0, 1'b0,
                                       1'b0);
          end else begin
            dec.num  = {st.vld, ~st.vld};
            dec.res0 = close_num;
            dec.res1 = st.res;
          end
        end
        jbt_pkg::MODE_STR: begin
          if (data_byte == jbt_pkg::CH_QUOTE) begin
            dec.num  = 2'd1;
            dec.res0 = jbt_pkg::mk_res(jbt_pkg::KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
          end else if (data_byte != jbt_pkg::CH_BSLASH) begin
            dec.num  = 2'd1;
            dec.res0 = jbt_pkg::mk_res(jbt_pkg::KIND_STR, data_byte, 1'b1, 1'b0, 1'b0,
                                       1'b0);
          end
        end
        jbt_pkg::MODE_ESC: begin
          dec.num  = 2'd1;
          dec.res0 = jbt_pkg::mk_res(jbt_pkg::KIND_STR, jbt_pkg::unescape(data_byte),
                                     1'b1, 1'b0, 1'b0, 1'b0);
        end
        default: begin
          // idle, and the unused codes
          dec.num  = {1'b0, st.vld};
          dec.res0 = st.res;
        end
      endcase
    end
  end

  // Mode register, advances once per byte leaving the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jbt_pkg::MODE_IDLE;
    end else if (fire) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// ===== sv/jbt_resq.sv =====
// ----------------------------------------------------------------------------
// jbt_resq: result queue
// Four-entry queue taking up to two results per cycle, giving one per cycle while deq_ready is high.
// ----------------------------------------------------------------------------
module jbt_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_num,
  input  jbt_pkg::res_t push0,
  input  jbt_pkg::res_t push1,
  output logic          room2,
  output logic          deq_valid,
  input  logic          deq_ready,
  output jbt_pkg::res_t deq_res
);

  jbt_pkg::res_t                      ent_r [jbt_pkg::QDEPTH];
  logic [jbt_pkg::QPTR_W-1:0]         wr_ptr_r;
  logic [jbt_pkg::QPTR_W-1:0]         wr_ptr_nxt;
  logic [jbt_pkg::QPTR_W-1:0]         rd_ptr_r;
  logic [jbt_pkg::QPTR_W-1:0]         rd_ptr_nxt;
  logic [jbt_pkg::QCNT_W-1:0]         cnt_r;
  logic [jbt_pkg::QCNT_W-1:0]         cnt_nxt;
  logic [jbt_pkg::QPTR_W-1:0]         wr_ptr_p1;
  logic                               pop;

  // Status and read side
  assign pop       = deq_valid && deq_ready;
  assign deq_valid = (cnt_r != '0);
  assign deq_res   = ent_r[rd_ptr_r];
  assign room2     = (cnt_r <= jbt_pkg::QCNT_W'(jbt_pkg::QDEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + jbt_pkg::QPTR_W'(1);

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + jbt_pkg::QPTR_W'(push_num);
    rd_ptr_nxt = rd_ptr_r + jbt_pkg::QPTR_W'(pop);
    cnt_nxt    = cnt_r + jbt_pkg::QCNT_W'(push_num) - jbt_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      ent_r[wr_ptr_r] <= push0;
    end
    if (push_num == 2'd2) begin
      ent_r[wr_ptr_p1] <= push1;
    end
  end

endmodule

// ===== sv/json_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// json_byte_tokenizer: streaming tokeniser for JSON-like text
// Marks punctuation, names, numbers and quoted strings byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  takes one text byte per transfer; end_of_input set closes any
//            open token (data_byte is then ignored).
//   out_chan gives result items: kind, byte, and first/last/error markers.
//   Each byte yields zero, one or two results; a byte that closes a name or
//   number and opens another token yields two.
// Path: a byte is staged in the input register, decoded against the
//   lexer mode and written to the result queue once the queue has room
//   for two results; the queue offers its results in order on out_chan.
// Throughput: one byte per cycle while each byte yields at most one result
//   and out_chan.ready stays high. The result queue drains one item per
//   cycle, so bytes yielding two results slow the input; the single result
//   port sets this and the four-entry queue only absorbs bursts.
// Reset: rst_n low for one edge empties the stage and the queue and returns
//   the lexer to idle with no token open.
// Stall: with out_chan.ready low the queue fills; once it cannot take two
//   more results the staged byte holds and in_chan.ready drops.
// ----------------------------------------------------------------------------
module json_byte_tokenizer (
  input  logic      clk,
  input  logic      rst_n,
  jbt_in_if.sink    in_chan,
  jbt_out_if.source out_chan
);

  logic          stg_vld_r;
  logic          stg_vld_nxt;
  logic [7:0]    stg_byte_r;
  logic          stg_eoi_r;
  logic          in_fire;
  logic          advance;
  logic          room2;
  logic [1:0]    push_num;
  jbt_pkg::dec_t dec;
  jbt_pkg::res_t deq_res;

  // Input stage handshake
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign advance        = stg_vld_r && room2;
  assign in_chan.ready  = !stg_vld_r || room2;
  assign stg_vld_nxt    = in_fire ? 1'b1 : (advance ? 1'b0 : stg_vld_r);
  assign push_num       = advance ? dec.num : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  // Staged payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_byte_r <= in_chan.data_byte;
      stg_eoi_r  <= in_chan.end_of_input;
    end
  end

  jbt_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (advance),
    .data_byte    (stg_byte_r),
    .end_of_input (stg_eoi_r),
    .dec          (dec)
  );

  jbt_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_num  (push_num),
    .push0     (dec.res0),
    .push1     (dec.res1),
    .room2     (room2),
    .deq_valid (out_chan.valid),
    .deq_ready (out_chan.ready),
    .deq_res   (deq_res)
  );

  // Result channel payload
  assign out_chan.token_kind     = deq_res.token_kind;
  assign out_chan.byte_value     = deq_res.byte_value;
  assign out_chan.has_byte       = deq_res.has_byte;
  assign out_chan.first_of_token = deq_res.first_of_token;
  assign out_chan.last_of_token  = deq_res.last_of_token;
  assign out_chan.string_error   = deq_res.string_error;

  // A staged byte blocked by a queue without room for two results keeps its payload
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && !room2 |=> stg_vld_r && $stable(stg_byte_r) && $stable(stg_eoi_r))
    else $error("staged byte lost while queue full");

  // After any push a result is offered on the next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    push_num != 2'd0 |=> out_chan.valid)
    else $error("pushed result not offered");

  // An unterminated string report is the only result of its byte
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    advance && dec.num != 2'd0 && dec.res0.string_error |->
      dec.num == 2'd1 && dec.res0.last_of_token && stg_eoi_r)
    else $error("string error outside end of input");

  // A second result always opens a new token
  a_second_opens: assert property (@(posedge clk) disable iff (!rst_n)
    advance && dec.num == 2'd2 |-> dec.res1.first_of_token && dec.res0.last_of_token)
    else $error("second result does not open a token");

endmodule

// ===== tb/tb_json_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tb_json_byte_tokenizer: self-checking bench for the JSON byte tokeniser
// Walks a short table of directed bytes, then streams random JSON-like text
// (names, numbers, strings with escapes, punctuation, whitespace and noise).
// Every accepted byte is run through a local token predictor; each result
// transfer is compared field by field with the oldest expected token item.
// Both channels stall at random, with one calm stretch and one full drain.
// ----------------------------------------------------------------------------
module tb_json_byte_tokenizer;

  localparam int RANDOM_ITEMS  = 750;
  localparam int STALL_PCT     = 17;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int DRAIN_CYCLES  = 20;

  // One row of the directed table; want_n < 0 means use the predictor
  typedef struct {
    logic [7:0]    b;
    logic          eoi;
    int            want_n;
    jbt_pkg::res_t want0;
    jbt_pkg::res_t want1;
  } stim_row_t;

  logic clk;
  logic rst_n;

  jbt_in_if  in_chan ();
  jbt_out_if out_chan ();

  json_byte_tokenizer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  jbt_pkg::mode_t lex_state;
  jbt_pkg::res_t  token_expect_q[$];
  stim_row_t      directed_rows[$];
  int             mismatch_count;
  int             live_items;
  bit             calm_run;

  string punct_set = ":,{}[]";
  string num_set   = "0123456789.eE+-";
  string ws_set    = " \t\n\r";

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  function automatic bit digit_ch(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic bit alpha_ch(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic bit name_ch(input logic [7:0] c);
    return alpha_ch(c) || digit_ch(c) || c == jbt_pkg::CH_USCORE;
  endfunction

  function automatic bit num_ch(input logic [7:0] c);
    return digit_ch(c) || c inside {jbt_pkg::CH_DOT, jbt_pkg::CH_LC_E, jbt_pkg::CH_UC_E,
                                    jbt_pkg::CH_PLUS, jbt_pkg::CH_MINUS};
  endfunction

  function automatic bit punct_ch(input logic [7:0] c);
    return c inside {jbt_pkg::CH_COLON, jbt_pkg::CH_COMMA, jbt_pkg::CH_LBRACE,
                     jbt_pkg::CH_RBRACE, jbt_pkg::CH_LBRACK, jbt_pkg::CH_RBRACK};
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] c);
    if (c == jbt_pkg::CH_LC_N) return jbt_pkg::CH_LF;
    if (c == jbt_pkg::CH_LC_T) return jbt_pkg::CH_TAB;
    if (c == jbt_pkg::CH_LC_R) return jbt_pkg::CH_CR;
    return c;
  endfunction

  function automatic jbt_pkg::res_t tok_item(input logic [1:0] kind, input logic [7:0] b,
                                             input bit has, input bit first,
                                             input bit last, input bit err);
    jbt_pkg::res_t r;
    r.token_kind     = kind;
    r.byte_value     = has ? b : 8'h00;
    r.has_byte       = has;
    r.first_of_token = first;
    r.last_of_token  = last;
    r.string_error   = err;
    return r;
  endfunction

  // Open a token from idle; returns 1 when an item comes out
  function automatic bit open_token(input logic [7:0] c, output jbt_pkg::res_t r);
    r = '0;
    lex_state = jbt_pkg::MODE_IDLE;
    if (punct_ch(c)) begin
      r = tok_item(jbt_pkg::KIND_PUNCT, c, 1'b1, 1'b1, 1'b1, 1'b0);
      return 1'b1;
    end
    if (c == jbt_pkg::CH_QUOTE) begin
      r = tok_item(jbt_pkg::KIND_STR, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
      lex_state = jbt_pkg::MODE_STR;
      return 1'b1;
    end
    if (digit_ch(c)) begin
      r = tok_item(jbt_pkg::KIND_NUM, c, 1'b1, 1'b1, 1'b0, 1'b0);
      lex_state = jbt_pkg::MODE_NUM;
      return 1'b1;
    end
    if (alpha_ch(c) || c == jbt_pkg::CH_USCORE) begin
      r = tok_item(jbt_pkg::KIND_NAME, c, 1'b1, 1'b1, 1'b0, 1'b0);
      lex_state = jbt_pkg::MODE_NAME;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the lexer by one input item; returns the number of results
  function automatic int tokenise_byte(input logic [7:0] c, input logic eoi,
                                       output jbt_pkg::res_t r0, output jbt_pkg::res_t r1);
    int n;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (eoi) begin
      case (lex_state)
        jbt_pkg::MODE_NAME: begin
          r0 = tok_item(jbt_pkg::KIND_NAME, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
          n  = 1;
        end
        jbt_pkg::MODE_NUM: begin
          r0 = tok_item(jbt_pkg::KIND_NUM, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
          n  = 1;
        end
        jbt_pkg::MODE_STR, jbt_pkg::MODE_ESC: begin
          r0 = tok_item(jbt_pkg::KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
          n  = 1;
        end
        default: ;
      endcase
      lex_state = jbt_pkg::MODE_IDLE;
      return n;
    end
    case (lex_state)
      jbt_pkg::MODE_NAME: begin
        if (name_ch(c)) begin
          r0 = tok_item(jbt_pkg::KIND_NAME, c, 1'b1, 1'b0, 1'b0, 1'b0);
          n  = 1;
        end else begin
          r0 = tok_item(jbt_pkg::KIND_NAME, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
          n  = 1 + int'(open_token(c, r1));
        end
      end
      jbt_pkg::MODE_NUM: begin
        if (num_ch(c)) begin
          r0 = tok_item(jbt_pkg::KIND_NUM, c, 1'b1, 1'b0, 1'b0, 1'b0);
          n  = 1;
        end else begin
          r0 = tok_item(jbt_pkg::KIND_NUM, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
          n  = 1 + int'(open_token(c, r1));
        end
      end
      jbt_pkg::MODE_STR: begin
        if (c == jbt_pkg::CH_QUOTE) begin
          r0 = tok_item(jbt_pkg::KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
          n  = 1;
          lex_state = jbt_pkg::MODE_IDLE;
        end else if (c == jbt_pkg::CH_BSLASH) begin
          lex_state = jbt_pkg::MODE_ESC;
        end else begin
          r0 = tok_item(jbt_pkg::KIND_STR, c, 1'b1, 1'b0, 1'b0, 1'b0);
          n  = 1;
        end
      end
      jbt_pkg::MODE_ESC: begin
        r0 = tok_item(jbt_pkg::KIND_STR, esc_map(c), 1'b1, 1'b0, 1'b0, 1'b0);
        n  = 1;
        lex_state = jbt_pkg::MODE_STR;
      end
      default: n = int'(open_token(c, r0));
    endcase
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Byte sender: random idle, then hold valid until the transfer
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic eoi, input int want_n = -1,
                           input jbt_pkg::res_t want0 = '0,
                           input jbt_pkg::res_t want1 = '0);
    jbt_pkg::res_t p0, p1;
    int            n;
    while (!calm_run && $urandom_range(0, 99) < STALL_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.data_byte    <= b;
    in_chan.end_of_input <= eoi;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
    n = tokenise_byte(b, eoi, p0, p1);
    live_items++;
    // Typed-in rows override the predictor, which still tracks the mode
    if (want_n >= 0) begin
      n  = want_n;
      p0 = want0;
      p1 = want1;
    end
    if (n > 0) token_expect_q.push_back(p0);
    if (n > 1) token_expect_q.push_back(p1);
  endtask

  // Drop valid and hold off until every expected token item has arrived
  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (token_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input logic eoi, input int want_n = -1,
                         input jbt_pkg::res_t want0 = '0,
                         input jbt_pkg::res_t want1 = '0);
    stim_row_t row;
    row.b      = b;
    row.eoi    = eoi;
    row.want_n = want_n;
    row.want0  = want0;
    row.want1  = want1;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Random text: mostly well-formed tokens, some noise and broken strings
  // ---------------------------------------------------------------------------
  task automatic send_fragment();
    int         pick;
    int         len;
    int         sel;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      send_item(punct_set[$urandom_range(0, 5)], 1'b0);
    end else if (pick < 36) begin
      // name: letter or underscore first
      sel = $urandom_range(0, 2);
      c = (sel == 0) ? jbt_pkg::CH_USCORE : (sel == 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                                       : 8'($urandom_range(8'h41, 8'h5A));
      send_item(c, 1'b0);
      len = $urandom_range(0, 7);
      repeat (len) begin
        sel = $urandom_range(0, 3);
        c = (sel == 0) ? jbt_pkg::CH_USCORE : (sel == 1) ? 8'($urandom_range(8'h30, 8'h39))
          : (sel == 2) ? 8'($urandom_range(8'h61, 8'h7A)) : 8'($urandom_range(8'h41, 8'h5A));
        send_item(c, 1'b0);
      end
    end else if (pick < 52) begin
      send_item(8'($urandom_range(8'h30, 8'h39)), 1'b0);
      len = $urandom_range(0, 6);
      repeat (len) send_item(num_set[$urandom_range(0, 14)], 1'b0);
    end else if (pick < 78) begin
      send_item(jbt_pkg::CH_QUOTE, 1'b0);
      len = $urandom_range(0, 8);
      repeat (len) begin
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
          send_item(jbt_pkg::CH_BSLASH, 1'b0);
          case ($urandom_range(0, 6))
            0:       c = jbt_pkg::CH_LC_N;
            1:       c = jbt_pkg::CH_LC_T;
            2:       c = jbt_pkg::CH_LC_R;
            3:       c = jbt_pkg::CH_QUOTE;
            4:       c = jbt_pkg::CH_BSLASH;
            default: c = 8'($urandom_range(0, 255));
          endcase
        end else if (sel < 35) begin
          c = 8'($urandom_range(0, 255));
          if (c == jbt_pkg::CH_QUOTE || c == jbt_pkg::CH_BSLASH) c = 8'h41;
        end else begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          if (c == jbt_pkg::CH_QUOTE || c == jbt_pkg::CH_BSLASH) c = 8'h7E;
        end
        send_item(c, 1'b0);
      end
      // close, or leave the string open at end of input
      sel = $urandom_range(0, 99);
      if (sel < 88) begin
        send_item(jbt_pkg::CH_QUOTE, 1'b0);
      end else begin
        if (sel >= 94) send_item(jbt_pkg::CH_BSLASH, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end else if (pick < 86) begin
      send_item(ws_set[$urandom_range(0, 3)], 1'b0);
    end else if (pick < 94) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure
  // ---------------------------------------------------------------------------
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= calm_run || ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // Result checker
  always @(posedge clk) begin
    jbt_pkg::res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (token_expect_q.size() == 0) begin
        note_mismatch("unexpected result, byte", out_chan.byte_value, 0);
      end else begin
        want = token_expect_q.pop_front();
        if (out_chan.token_kind !== want.token_kind)
          note_mismatch("token_kind", out_chan.token_kind, want.token_kind);
        if (out_chan.byte_value !== want.byte_value)
          note_mismatch("byte_value", out_chan.byte_value, want.byte_value);
        if (out_chan.has_byte !== want.has_byte)
          note_mismatch("has_byte", out_chan.has_byte, want.has_byte);
        if (out_chan.first_of_token !== want.first_of_token)
          note_mismatch("first_of_token", out_chan.first_of_token, want.first_of_token);
        if (out_chan.last_of_token !== want.last_of_token)
          note_mismatch("last_of_token", out_chan.last_of_token, want.last_of_token);
        if (out_chan.string_error !== want.string_error)
          note_mismatch("string_error", out_chan.string_error, want.string_error);
      end
    end
  end

  // Watchdog: cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_MAX) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_MAX);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit paused;
    in_chan.valid        = 1'b0;
    in_chan.data_byte    = 8'h00;
    in_chan.end_of_input = 1'b0;
    rst_n          = 1'b0;
    lex_state      = jbt_pkg::MODE_IDLE;
    mismatch_count = 0;
    live_items     = 0;
    calm_run       = 1'b0;
    paused         = 1'b0;

    // Directed table: end of input while idle, extremes, every token kind,
    // unknown bytes, raw bytes in strings, escapes and an unterminated string
    add_row(8'hFF, 1'b1, 0);
    add_row(jbt_pkg::CH_LBRACE, 1'b0, 1,
            tok_item(jbt_pkg::KIND_PUNCT, jbt_pkg::CH_LBRACE, 1'b1, 1'b1, 1'b1, 1'b0));
    add_row(8'h00, 1'b0, 0);
    add_row(8'hFF, 1'b0, 0);
    add_row(" ", 1'b0, 0);
    add_row("a", 1'b0, 1, tok_item(jbt_pkg::KIND_NAME, "a", 1'b1, 1'b1, 1'b0, 1'b0));
    add_row(jbt_pkg::CH_USCORE, 1'b0);
    add_row("9", 1'b0);
    add_row(jbt_pkg::CH_COLON, 1'b0, 2,
            tok_item(jbt_pkg::KIND_NAME, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0),
            tok_item(jbt_pkg::KIND_PUNCT, jbt_pkg::CH_COLON, 1'b1, 1'b1, 1'b1, 1'b0));
    add_row("0", 1'b0, 1, tok_item(jbt_pkg::KIND_NUM, "0", 1'b1, 1'b1, 1'b0, 1'b0));
    add_row(jbt_pkg::CH_DOT, 1'b0);
    add_row(jbt_pkg::CH_UC_E, 1'b0);
    add_row(jbt_pkg::CH_MINUS, 1'b0);
    add_row("Z", 1'b0, 2, tok_item(jbt_pkg::KIND_NUM, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0),
            tok_item(jbt_pkg::KIND_NAME, "Z", 1'b1, 1'b1, 1'b0, 1'b0));
    add_row(8'h00, 1'b1, 1, tok_item(jbt_pkg::KIND_NAME, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
    add_row(jbt_pkg::CH_QUOTE, 1'b0, 1,
            tok_item(jbt_pkg::KIND_STR, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
    add_row(8'h00, 1'b0, 1, tok_item(jbt_pkg::KIND_STR, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(8'hFF, 1'b0, 1, tok_item(jbt_pkg::KIND_STR, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(jbt_pkg::CH_BSLASH, 1'b0, 0);
    add_row(jbt_pkg::CH_LC_N, 1'b0, 1,
            tok_item(jbt_pkg::KIND_STR, jbt_pkg::CH_LF, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(jbt_pkg::CH_BSLASH, 1'b0);
    add_row("q", 1'b0);
    add_row(jbt_pkg::CH_QUOTE, 1'b0, 1,
            tok_item(jbt_pkg::KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
    add_row(jbt_pkg::CH_QUOTE, 1'b0);
    add_row(jbt_pkg::CH_BSLASH, 1'b0);
    add_row(8'h00, 1'b1, 1, tok_item(jbt_pkg::KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].b, directed_rows[i].eoi, directed_rows[i].want_n,
                directed_rows[i].want0, directed_rows[i].want1);

    // Random text with a calm stretch and one full drain part way through
    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      calm_run = (live_items >= 250) && (live_items < 420);
      if (!paused && live_items >= 500) begin
        paused = 1'b1;
        wait_drain();
      end
      send_fragment();
    end
    calm_run = 1'b0;

    // Drain, then let the pipeline settle
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== json_byte_tokenizer.f =====
sv/jbt_pkg.sv
sv/jbt_if.sv
sv/jbt_decode.sv
sv/jbt_resq.sv
sv/json_byte_tokenizer.sv
tb/tb_json_byte_tokenizer.sv
